// ===== sv/ccal_pkg.sv =====
// Shared types and constants for the credential allowlist checker.
`default_nettype none

package ccal_pkg;

    localparam logic [1:0] MODE_ID    = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_DENIED   = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [4:0] LEN_SAT   = 5'd31;
    localparam logic [4:0] DEC_BASE  = 5'd10;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    typedef struct packed {
        logic take;
        logic eval;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic id_bad;
        logic scan_hit;
        logic scan_over;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/credential_check_allowlist_core.sv =====
// Top level of the credential allowlist checker: sequencer plus datapath.
//
// Bytes are presented with start while busy is low; mode selects a credential byte,
// an allowlist entry byte or a clear of the allowlist. Every byte except the final
// credential byte is taken while busy stays low. The final credential byte raises busy:
// a format or checksum error keeps busy high for one cycle and its status follows
// in the next, while a well-formed ID walks the stored entries one per cycle over
// the single memory read port, so busy ends on a match or once every stored entry
// has been compared. The status word appears for one cycle with done, in the first
// cycle with busy low again, and cannot be held off by the receiver.
`default_nettype none

module credential_check_allowlist_core #(
    parameter int ID_DIGITS   = 10,
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] char_byte,
    input  wire logic       last_char,
    output logic            done,
    output logic [1:0]      status
);
    import ccal_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ccal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .last_char (last_char),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    ccal_datapath #(
        .ID_DIGITS   (ID_DIGITS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mode      (mode),
        .char_byte (char_byte),
        .last_char (last_char),
        .stat      (stat),
        .done      (done),
        .status    (status)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("status word without a check in progress");

    a_final_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_ID && last_char) |=> busy)
        else $error("final credential byte did not start a check");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy)) |-> $past(start && mode == MODE_ID && last_char))
        else $error("busy raised without a final credential byte");

endmodule

`default_nettype wire

// ===== sv/ccal_ctrl.sv =====
// Sequencer for the credential allowlist checker.
`default_nettype none

module ccal_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           mode,
    input  wire logic                 last_char,
    input  wire ccal_pkg::dp_stat_t   stat,
    output logic                      busy,
    output ccal_pkg::ctrl_cmd_t       cmd
);
    import ccal_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.take = start;
                if (start && mode == MODE_ID && last_char)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cmd.finish = stat.id_bad;
                state_next = stat.id_bad ? S_IDLE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                cmd.finish = stat.scan_hit | stat.scan_over;
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ccal_datapath.sv =====
// Accumulators, allowlist memory and entry walk for the credential checker.
`default_nettype none

module ccal_datapath #(
    parameter int ID_DIGITS   = 10,
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ccal_pkg::ctrl_cmd_t  cmd,
    input  wire logic [1:0]           mode,
    input  wire logic [7:0]           char_byte,
    input  wire logic                 last_char,
    output ccal_pkg::dp_stat_t        stat,
    output logic                      done,
    output logic [1:0]                status
);
    import ccal_pkg::*;

    localparam int SH_W  = 4 * ID_DIGITS;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [SH_W-1:0]  id_shift_reg,  id_shift_next;
    logic [4:0]       id_len_reg,    id_len_next;
    logic             id_nd_reg,     id_nd_next;
    logic [3:0]       sum_reg,       sum_next;
    logic [3:0]       newest_reg,    newest_next;
    logic [SH_W-1:0]  ld_shift_reg,  ld_shift_next;
    logic [4:0]       ld_len_reg,    ld_len_next;
    logic             ld_nd_reg,     ld_nd_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] issue_reg,     issue_next;
    logic             rd_vld_reg,    rd_vld_next;
    logic             done_reg,      done_next;
    logic [1:0]       status_reg,    status_next;
    logic [SH_W-1:0]  rd_data_reg;

    logic [SH_W-1:0] mem [MAX_ENTRIES];

    logic            is_digit;
    logic [3:0]      digit;
    logic [7:0]      char_off;
    logic [4:0]      sum_wide;
    logic            fmt_bad;
    logic            ck_bad;
    logic            store_en;
    logic            rd_en;

    assign char_off = char_byte - CHAR_ZERO;
    assign digit    = char_off[3:0];
    assign is_digit = char_byte inside {[CHAR_ZERO:CHAR_NINE]};
    assign sum_wide = {1'b0, sum_reg} + {1'b0, newest_reg};

    assign fmt_bad = id_nd_reg || (id_len_reg != 5'(ID_DIGITS));
    assign ck_bad  = newest_reg != sum_reg;

    assign stat.id_bad    = fmt_bad | ck_bad;
    assign stat.scan_hit  = rd_vld_reg && (rd_data_reg == id_shift_reg);
    assign stat.scan_over = !rd_vld_reg && (issue_reg >= count_reg);

    assign rd_en = cmd.scan && !cmd.finish && (issue_reg < count_reg);

    always_comb
    begin
        id_shift_next = id_shift_reg;
        id_len_next   = id_len_reg;
        id_nd_next    = id_nd_reg;
        sum_next      = sum_reg;
        newest_next   = newest_reg;
        ld_shift_next = ld_shift_reg;
        ld_len_next   = ld_len_reg;
        ld_nd_next    = ld_nd_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        rd_vld_next   = rd_vld_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        store_en      = 1'b0;

        if (cmd.take)
        begin
            case (mode)
                MODE_ID:
                begin
                    if (id_len_reg < LEN_SAT)
                    begin
                        id_len_next = id_len_reg + 5'd1;
                    end
                    if (is_digit)
                    begin
                        sum_next      = (sum_wide >= DEC_BASE) ? 4'(sum_wide - DEC_BASE)
                                                               : sum_wide[3:0];
                        newest_next   = digit;
                        id_shift_next = {id_shift_reg[SH_W-5:0], digit};
                    end
                    else
                    begin
                        id_nd_next = 1'b1;
                    end
                end
                MODE_LOAD:
                begin
                    if (ld_len_reg < LEN_SAT)
                    begin
                        ld_len_next = ld_len_reg + 5'd1;
                    end
                    if (is_digit)
                    begin
                        ld_shift_next = {ld_shift_reg[SH_W-5:0], digit};
                    end
                    else
                    begin
                        ld_nd_next = 1'b1;
                    end
                    if (last_char)
                    begin
                        // store only a clean, full-length entry while room remains
                        if (!ld_nd_next && ld_len_next == 5'(ID_DIGITS)
                            && count_reg < CNT_W'(MAX_ENTRIES))
                        begin
                            store_en   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        ld_len_next = '0;
                        ld_nd_next  = 1'b0;
                    end
                end
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.eval && !cmd.finish)
        begin
            issue_next  = '0;
            rd_vld_next = 1'b0;
        end

        if (rd_en)
        begin
            issue_next  = issue_reg + CNT_W'(1);
            rd_vld_next = 1'b1;
        end
        else if (cmd.scan)
        begin
            rd_vld_next = 1'b0;
        end

        if (cmd.finish)
        begin
            done_next = 1'b1;
            if (cmd.eval)
            begin
                status_next = fmt_bad ? ST_FORMAT : ST_CHECKSUM;
            end
            else
            begin
                status_next = stat.scan_hit ? ST_OK : ST_DENIED;
            end
            id_shift_next = '0;
            id_len_next   = '0;
            id_nd_next    = 1'b0;
            sum_next      = '0;
            newest_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_shift_reg <= '0;
            id_len_reg   <= '0;
            id_nd_reg    <= 1'b0;
            sum_reg      <= '0;
            newest_reg   <= '0;
            ld_shift_reg <= '0;
            ld_len_reg   <= '0;
            ld_nd_reg    <= 1'b0;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            id_shift_reg <= id_shift_next;
            id_len_reg   <= id_len_next;
            id_nd_reg    <= id_nd_next;
            sum_reg      <= sum_next;
            newest_reg   <= newest_next;
            ld_shift_reg <= ld_shift_next;
            ld_len_reg   <= ld_len_next;
            ld_nd_reg    <= ld_nd_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= ld_shift_next;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
        end
    end

    assign done   = done_reg;
    assign status = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> issue_reg <= count_reg)
        else $error("walk ran past the stored entries");

endmodule

`default_nettype wire
